@@ rtl/core/dshi_pkg.sv @@
// Shared types and constants of the delayed sample history interpolator.
// Used by the controller, the datapath and the top level; depends on nothing.
package dshi_pkg;

    localparam int TIME_W    = 48;
    localparam int FORCE_W   = 32;
    localparam int DELAY_W   = 17;
    localparam int LIMIT_W   = 20;
    localparam int FRAC_W    = 16;
    localparam int NUM_AXES  = 3;
    localparam int DEF_DEPTH = 32;

    localparam logic [DELAY_W-1:0] DELAY_MAX   = 17'd100000;
    localparam logic [LIMIT_W-1:0] GAP_RESET   = 20'd100000;
    localparam logic [LIMIT_W-1:0] STALE_RESET = 20'd100000;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DELAY = 2'd0;
    localparam logic [1:0] REG_GAP   = 2'd1;
    localparam logic [1:0] REG_STALE = 2'd2;

    // Result selection commands.
    localparam logic [1:0] RES_KEEP   = 2'd0;
    localparam logic [1:0] RES_INVAL  = 2'd1;
    localparam logic [1:0] RES_NEWEST = 2'd2;
    localparam logic [1:0] RES_OLDER  = 2'd3;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [LIMIT_W-1:0] gap;
        logic [LIMIT_W-1:0] stale;
    } t_cfg;

    typedef struct packed {
        logic       latch;
        logic       push;
        logic       rd_newest;
        logic       scan_init;
        logic       rd_scan;
        logic       chk_scan;
        logic       div_init;
        logic       div_step;
        logic       mul;
        logic       add;
        logic [1:0] res_sel;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic stale;
        logic at_newest;
        logic scan_hit;
        logic scan_end;
        logic has_older;
        logic interp;
        logic div_last;
        logic axis_last;
        logic out_full;
    } t_stat;

endpackage

@@ rtl/core/dshi_ctrl.sv @@
// Sequencer of the delayed sample history interpolator.
// Depends on dshi_pkg; drives the datapath through t_cmd and reads t_stat.
module dshi_ctrl
    import dshi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_kind,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output logic  o_s_ready,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PUSH = 4'd1;
    localparam logic [3:0] S_QRD  = 4'd2;
    localparam logic [3:0] S_QCHK = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_SCHK = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_kind ? S_QRD : S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_IDLE;
            end
            S_QRD: begin
                if (i_stat.empty) begin
                    o_cmd.res_sel = RES_INVAL;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rd_newest = 1'b1;
                    n_state         = S_QCHK;
                end
            end
            S_QCHK: begin
                if (i_stat.stale) begin
                    o_cmd.res_sel = RES_INVAL;
                    n_state       = S_OUT;
                end else if (i_stat.at_newest) begin
                    o_cmd.res_sel = RES_NEWEST;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_SCHK;
            end
            S_SCHK: begin
                o_cmd.chk_scan = 1'b1;
                n_state = (i_stat.scan_hit || i_stat.scan_end) ? S_DEC : S_SRD;
            end
            S_DEC: begin
                if (!i_stat.has_older) begin
                    o_cmd.res_sel = RES_INVAL;
                    n_state       = S_OUT;
                end else if (i_stat.interp) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.res_sel = RES_OLDER;
                    n_state       = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_stat.axis_last ? S_OUT : S_MUL;
            end
            S_OUT: begin
                // Wait until the output register is free or being emptied.
                if (!i_stat.out_full || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> (r_state != S_IDLE))
        else $error("controller stayed idle after taking an item");

    a_state_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= S_OUT)
        else $error("controller in an unused state");

    a_push_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_state == S_IDLE))
        else $error("push took more than one cycle");

endmodule

@@ rtl/core/dshi_dp.sv @@
// Datapath of the delayed sample history interpolator: sample ring memory,
// bracket search registers, serial divider, interpolator and output register.
// Depends on dshi_pkg; controlled by dshi_ctrl.
module dshi_dp
    import dshi_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_cmd                        i_cmd,
    input  logic [2*TIME_W+3*FORCE_W-1:0] i_in_data,
    input  logic                        i_in_ok,
    input  logic                        i_m_ready,
    output t_stat                       o_stat,
    output logic                        o_m_valid,
    output logic                        o_m_flag,
    output logic [3*FORCE_W-1:0]        o_m_data
);

    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int MEM_W  = TIME_W + 3 * FORCE_W;
    localparam int PROD_W = FORCE_W + FRAC_W + 2;
    localparam int DCW    = $clog2(FRAC_W);

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [AW+1:0] sum;
        sum = {2'b00, base} + (AW+2)'(off);
        if (sum >= (AW+2)'(DEPTH)) begin
            sum = sum - (AW+2)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Ring storage: time in the low bits, then x, y and z force.
    logic [MEM_W-1:0] r_mem [DEPTH];
    logic [MEM_W-1:0] r_rd;

    logic [AW-1:0]     r_oldest;
    logic [CW-1:0]     r_fill;
    logic [TIME_W-1:0] r_last;

    logic [TIME_W-1:0]        r_in_time;
    logic [TIME_W-1:0]        r_in_now;
    logic                     r_in_ok;
    logic [3*FORCE_W-1:0]     r_in_force;
    logic [TIME_W-1:0]        r_target;

    logic [CW-1:0]            r_idx;
    logic                     r_has_older;
    logic                     r_has_newer;
    logic [TIME_W-1:0]        r_t0;
    logic [TIME_W-1:0]        r_t1;
    logic signed [FORCE_W-1:0] r_f0 [NUM_AXES];
    logic signed [FORCE_W-1:0] r_f1 [NUM_AXES];

    logic [TIME_W-1:0]        r_rem;
    logic [TIME_W-1:0]        r_span;
    logic [FRAC_W-1:0]        r_q;
    logic [DCW-1:0]           r_dcnt;
    logic [1:0]               r_ax;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_res_valid;
    logic [FORCE_W-1:0]       r_res [NUM_AXES];
    logic                     r_o_valid;
    logic                     r_o_flag;
    logic [3*FORCE_W-1:0]     r_o_data;

    logic [TIME_W-1:0]  rd_time;
    logic [FORCE_W-1:0] rd_f [NUM_AXES];
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic               gap_hit;
    logic [DELAY_W-1:0] delay_sat;
    logic [TIME_W-1:0]  in_ref;
    logic [TIME_W:0]    rem2;
    logic               rem_ge;
    logic signed [FORCE_W:0]     diff;
    logic signed [PROD_W-1:0]    shifted;

    assign rd_time = r_rd[TIME_W-1:0];
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            rd_f[a] = r_rd[TIME_W + FORCE_W*a +: FORCE_W];
        end
    end

    assign rd_addr = i_cmd.rd_newest ? f_slot(r_oldest, r_fill - CW'(1))
                                     : f_slot(r_oldest, r_idx);

    // A push lands only when it is newer than the last one stored.
    assign gap_hit = (r_last != '0) &&
                     ({1'b0, r_in_time} > ({1'b0, r_last} + (TIME_W+1)'(i_cfg.gap)));
    assign wr_en   = i_cmd.push && r_in_ok && (r_in_time > r_last);
    always_comb begin
        if (gap_hit) begin
            wr_addr = '0;
        end else if (r_fill < CW'(DEPTH)) begin
            wr_addr = f_slot(r_oldest, r_fill);
        end else begin
            wr_addr = r_oldest;
        end
    end

    assign delay_sat = (i_cfg.delay > DELAY_MAX) ? DELAY_MAX : i_cfg.delay;
    assign in_ref    = i_in_data[TIME_W-1:0];

    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = rem2 >= {1'b0, r_span};

    assign diff    = {r_f1[r_ax][FORCE_W-1], r_f1[r_ax]} - {r_f0[r_ax][FORCE_W-1], r_f0[r_ax]};
    assign shifted = r_prod >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_in_force, r_in_time};
        end
        if (i_cmd.rd_newest || i_cmd.rd_scan) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fill   <= '0;
            r_last   <= '0;
        end else if (wr_en) begin
            r_last <= r_in_time;
            if (gap_hit) begin
                r_oldest <= '0;
                r_fill   <= CW'(1);
            end else if (r_fill < CW'(DEPTH)) begin
                r_fill <= r_fill + CW'(1);
            end else begin
                r_oldest <= f_slot(r_oldest, CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in_time  <= in_ref;
            r_in_now   <= i_in_data[2*TIME_W-1:TIME_W];
            r_in_ok    <= i_in_ok;
            r_in_force <= i_in_data[2*TIME_W +: 3*FORCE_W];
            r_target   <= (in_ref > TIME_W'(delay_sat)) ? in_ref - TIME_W'(delay_sat) : '0;
        end
    end

    // Bracket search over the stored samples, oldest first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_has_older <= 1'b0;
            r_has_newer <= 1'b0;
        end else if (i_cmd.scan_init) begin
            r_idx       <= '0;
            r_has_older <= 1'b0;
            r_has_newer <= 1'b0;
        end else if (i_cmd.chk_scan) begin
            r_idx <= r_idx + CW'(1);
            if (rd_time <= r_target) begin
                r_has_older <= 1'b1;
            end
            if (rd_time >= r_target) begin
                r_has_newer <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk_scan) begin
            if (rd_time <= r_target) begin
                r_t0 <= rd_time;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_f0[a] <= rd_f[a];
                end
            end
            if (rd_time >= r_target) begin
                r_t1 <= rd_time;
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_f1[a] <= rd_f[a];
                end
            end
        end
    end

    // Restoring divider, one fraction bit per cycle; the offset is below the span.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem  <= r_target - r_t0;
            r_span <= r_t1 - r_t0;
            r_q    <= '0;
            r_dcnt <= '0;
            r_ax   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? TIME_W'(rem2 - {1'b0, r_span}) : rem2[TIME_W-1:0];
            r_q    <= {r_q[FRAC_W-2:0], rem_ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end else if (i_cmd.add) begin
            r_ax <= r_ax + 2'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= diff * $signed({1'b0, r_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_res_valid <= 1'b1;
            r_res[r_ax] <= r_f0[r_ax] + shifted[FORCE_W-1:0];
        end else begin
            case (i_cmd.res_sel)
                RES_INVAL: begin
                    r_res_valid <= 1'b0;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_res[a] <= '0;
                    end
                end
                RES_NEWEST: begin
                    r_res_valid <= 1'b1;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_res[a] <= rd_f[a];
                    end
                end
                RES_OLDER: begin
                    r_res_valid <= 1'b1;
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_res[a] <= r_f0[a];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_flag <= r_res_valid;
            r_o_data <= r_res_valid ? {r_res[2], r_res[1], r_res[0]} : '0;
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_m_flag  = r_o_flag;
    assign o_m_data  = r_o_data;

    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.stale     = ((r_in_now - rd_time) >= TIME_W'(i_cfg.stale));
    assign o_stat.at_newest = (r_target >= rd_time);
    assign o_stat.scan_hit  = (rd_time >= r_target);
    assign o_stat.scan_end  = ((r_idx + CW'(1)) == r_fill);
    assign o_stat.has_older = r_has_older;
    assign o_stat.interp    = r_has_newer && (r_t1 > r_t0);
    assign o_stat.div_last  = (r_dcnt == DCW'(FRAC_W - 1));
    assign o_stat.axis_last = (r_ax == 2'(NUM_AXES - 1));
    assign o_stat.out_full  = r_o_valid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("ring fill count beyond depth");

    a_oldest_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> (r_fill == CW'(DEPTH)))
        else $error("oldest slot moved while ring not full");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_o_valid)
        else $error("loaded result not presented");

endmodule

@@ rtl/core/delayed_sample_history_interpolator_top.sv @@
// Top level of the delayed sample history interpolator: stream ports,
// configuration registers on the APB-style port, controller and datapath.
// Depends on dshi_pkg, dshi_ctrl and dshi_dp.
//
//   Group    Dir  Payload
//   s_axis   in   tdata {force_z, force_y, force_x, now_us, time_us}, tuser {sample_ok, kind}
//   m_axis   out  tdata {out_z, out_y, out_x}, tuser {valid_res}
//   apb      in   lookback delay @0x0, gap_limit_us @0x4, stale_limit_us @0x8
//
// A push item is latched in S_IDLE and written in S_PUSH. A query item walks the
// stored samples one at a time through the single ring read port, then runs the
// one-bit-per-cycle divider when it interpolates, so its duration grows with the walk.
// Reset clears the ring to empty; the sample memory itself is not cleared.
// A result waiting in the output register holds the next query in its last
// cycle, and no further item is taken until that query's result is loaded.
module delayed_sample_history_interpolator_top
    import dshi_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*TIME_W+3*FORCE_W-1:0] s_axis_tdata,  // time_us, now_us, force_x, y, z
    input  logic [1:0]                    s_axis_tuser,  // kind, sample_ok
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [3*FORCE_W-1:0]          m_axis_tdata,  // out_x, out_y, out_z
    output logic                          m_axis_tuser,  // valid_res
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay <= '0;
            r_cfg.gap   <= GAP_RESET;
            r_cfg.stale <= STALE_RESET;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_DELAY: r_cfg.delay <= pwdata[DELAY_W-1:0];
                REG_GAP:   r_cfg.gap   <= pwdata[LIMIT_W-1:0];
                REG_STALE: r_cfg.stale <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DELAY: prdata = 32'(r_cfg.delay);
            REG_GAP:   prdata = 32'(r_cfg.gap);
            REG_STALE: prdata = 32'(r_cfg.stale);
            default:   prdata = '0;
        endcase
    end

    dshi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser[0]),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    dshi_dp #(
        .DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (cmd),
        .i_in_data (s_axis_tdata),
        .i_in_ok   (s_axis_tuser[1]),
        .i_m_ready (m_axis_tready),
        .o_stat    (stat),
        .o_m_valid (m_axis_tvalid),
        .o_m_flag  (m_axis_tuser),
        .o_m_data  (m_axis_tdata)
    );

endmodule

@@ sim/delayed_sample_history_interpolator_top_test.sv @@
// Self-checking bench for the delayed sample history interpolator top level.
// Drives push and query items on the input stream, writes the delay and limit
// registers between phases and checks every result against an internal predictor.
module delayed_sample_history_interpolator_top_test;
    import dshi_pkg::*;

    localparam int DEPTH = DEF_DEPTH;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 600;
    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] time_us;
        logic [TIME_W-1:0] now_us;
        logic              sample_ok;
        logic [FORCE_W-1:0] fx;
        logic [FORCE_W-1:0] fy;
        logic [FORCE_W-1:0] fz;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic [FORCE_W-1:0] x;
        logic [FORCE_W-1:0] y;
        logic [FORCE_W-1:0] z;
    } t_force;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [2*TIME_W+3*FORCE_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [3*FORCE_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    delayed_sample_history_interpolator_top dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    logic [TIME_W-1:0]  hist_time [DEPTH];
    logic [FORCE_W-1:0] hist_force [DEPTH][3];
    int unsigned oldest, fill;
    logic [TIME_W-1:0]  last_push = '0;
    logic [DELAY_W-1:0] cfg_delay = '0;
    logic [LIMIT_W-1:0] cfg_gap = GAP_RESET;
    logic [LIMIT_W-1:0] cfg_stale = STALE_RESET;

    t_item  pending_items[$];
    t_force expected_forces[$];
    int errors = 0;
    int cycles = 0;

    logic src_calm = 1'b0, sink_calm = 1'b0;
    logic sink_hold;
    logic hold_req = 1'b0;
    int unsigned hold_left = 0;
    logic src_pause = 1'b0;
    logic in_done = 1'b0;

    function automatic longint floor16(longint p);
        if (p >= 0) return p >>> 16;
        return -(((-p) + 65535) >>> 16);
    endfunction

    function automatic void store_push(t_item it);
        int unsigned slot;
        if (!it.sample_ok || it.time_us <= last_push) return;
        if (last_push != 0 && {1'b0, it.time_us} > {1'b0, last_push} + cfg_gap) begin
            fill = 0;
            oldest = 0;
        end
        if (fill < DEPTH) begin
            slot = (oldest + fill) % DEPTH;
            fill++;
        end else begin
            slot = oldest;
            oldest = (oldest + 1) % DEPTH;
        end
        hist_time[slot] = it.time_us;
        hist_force[slot][0] = it.fx;
        hist_force[slot][1] = it.fy;
        hist_force[slot][2] = it.fz;
        last_push = it.time_us;
    endfunction

    function automatic t_force delayed_force(t_item it);
        t_force r;
        int unsigned newest, s, older, newer;
        bit has_older, has_newer;
        logic [TIME_W-1:0] age, dly, target, span, off;
        longint frac, f0, f1, v;
        logic [FORCE_W-1:0] res [3];
        r = '0;
        has_older = 0;
        has_newer = 0;
        older = 0;
        newer = 0;
        if (fill == 0) return r;
        newest = (oldest + fill - 1) % DEPTH;
        age = it.now_us - hist_time[newest];
        if (age >= cfg_stale) return r;
        dly = (cfg_delay > DELAY_MAX) ? DELAY_MAX : cfg_delay;
        target = (it.time_us > dly) ? it.time_us - dly : '0;
        if (target >= hist_time[newest]) begin
            r = {1'b1, hist_force[newest][0], hist_force[newest][1], hist_force[newest][2]};
            return r;
        end
        for (int i = 0; i < fill; i++) begin
            s = (oldest + i) % DEPTH;
            if (hist_time[s] <= target) begin
                older = s;
                has_older = 1;
            end
            if (hist_time[s] >= target) begin
                newer = s;
                has_newer = 1;
                break;
            end
        end
        if (!has_older) return r;
        for (int a = 0; a < 3; a++) res[a] = hist_force[older][a];
        if (has_newer && hist_time[newer] > hist_time[older]) begin
            span = hist_time[newer] - hist_time[older];
            off = target - hist_time[older];
            frac = longint'(({16'd0, off} << 16) / {16'd0, span});
            for (int a = 0; a < 3; a++) begin
                f0 = longint'(signed'(hist_force[older][a]));
                f1 = longint'(signed'(hist_force[newer][a]));
                v = f0 + floor16((f1 - f0) * frac);
                res[a] = v[FORCE_W-1:0];
            end
        end
        r = {1'b1, res[0], res[1], res[2]};
        return r;
    endfunction

    // Receiver hold-off, counted here once requested.
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
        else if (hold_req) hold_left <= HOLD_CYCLES;
    end
    assign sink_hold = (hold_left != 0);

    // Driver.
    t_item cur;
    always @(negedge i_clk) begin
        if (s_axis_tvalid && !in_done) begin
            // hold the offered item
        end else if (!src_pause && pending_items.size() > 0
                     && (src_calm || $urandom_range(99) >= 32)) begin
            cur = pending_items.pop_front();
            s_axis_tdata <= {cur.fz, cur.fy, cur.fx, cur.now_us, cur.time_us};
            s_axis_tuser <= {cur.sample_ok, cur.kind};
            s_axis_tvalid <= 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
        m_axis_tready <= !sink_hold && (sink_calm || $urandom_range(99) >= 32);
    end

    // Input side: run the predictor on each accepted item.
    t_item acc;
    always @(posedge i_clk) begin
        in_done = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_done) begin
            acc.kind = s_axis_tuser[0];
            acc.sample_ok = s_axis_tuser[1];
            {acc.fz, acc.fy, acc.fx, acc.now_us, acc.time_us} = s_axis_tdata;
            if (acc.kind == KIND_PUSH) store_push(acc);
            else expected_forces.push_back(delayed_force(acc));
        end
    end

    // Monitor.
    t_force want;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_forces.size() == 0) begin
                $error("result with none expected: valid_res=%0d", m_axis_tuser);
                errors = errors + 1;
            end else begin
                want = expected_forces.pop_front();
                if (m_axis_tuser !== want.ok) begin
                    $error("valid_res expected %0d actual %0d", want.ok, m_axis_tuser);
                    errors = errors + 1;
                end
                if (m_axis_tdata[31:0] !== want.x) begin
                    $error("out_x expected %h actual %h", want.x, m_axis_tdata[31:0]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[63:32] !== want.y) begin
                    $error("out_y expected %h actual %h", want.y, m_axis_tdata[63:32]);
                    errors = errors + 1;
                end
                if (m_axis_tdata[95:64] !== want.z) begin
                    $error("out_z expected %h actual %h", want.z, m_axis_tdata[95:64]);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus helpers.
    logic [TIME_W-1:0] clock_us = 48'd1000;

    function automatic logic [FORCE_W-1:0] rand_force();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_push(logic [TIME_W-1:0] t, logic ok);
        t_item it;
        it.kind = KIND_PUSH;
        it.time_us = t;
        it.now_us = TIME_W'({$urandom, $urandom});
        it.sample_ok = ok;
        it.fx = rand_force();
        it.fy = rand_force();
        it.fz = rand_force();
        pending_items.push_back(it);
    endtask

    task automatic add_query(logic [TIME_W-1:0] t, logic [TIME_W-1:0] now);
        t_item it;
        it = '0;
        it.kind = KIND_QUERY;
        it.time_us = t;
        it.now_us = now;
        it.sample_ok = 1'($urandom_range(1));
        it.fx = $urandom;
        it.fy = $urandom;
        it.fz = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_forces.size() > 0)
            @(posedge i_clk);
        // A trailing push may still be in progress.
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DELAY: cfg_delay = val[DELAY_W-1:0];
            REG_GAP:   cfg_gap = val[LIMIT_W-1:0];
            REG_STALE: cfg_stale = val[LIMIT_W-1:0];
            default: begin
            end
        endcase
    endtask

    // A well-formed burst: increasing pushes followed by queries near them.
    task automatic add_burst(int n_push, int n_query, int unsigned step_max);
        logic [TIME_W-1:0] first;
        first = clock_us;
        for (int i = 0; i < n_push; i++) begin
            clock_us += $urandom_range(step_max, 1);
            add_push(clock_us, $urandom_range(9) != 0);
        end
        for (int i = 0; i < n_query; i++)
            add_query(first + $urandom_range(32'(clock_us - first) + 3000),
                      clock_us + $urandom_range(int'(cfg_stale) + 20));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty ring, push at zero, extremes, stale, exact hit, full ring.
        add_query(48'd5, 48'd5);
        add_push(48'd0, 1'b1);
        add_query(48'd5, 48'd5);
        add_push(48'd100, 1'b1);
        add_push(48'd100, 1'b1);
        add_push(48'd150, 1'b0);
        add_push(48'd200, 1'b1);
        add_query(48'd200, 48'd200);
        add_query(48'd100, 48'd250);
        add_query(48'd173, 48'd250);
        add_query(48'd50, 48'd250);
        add_query(48'hFFFF_FFFF_FFFF, 48'd199);
        add_query(48'd150, 48'd100200);
        add_query(48'd150, 48'd100199);
        add_push(48'd200000, 1'b1);
        add_query(48'd100, 48'd200000);
        for (int i = 1; i <= 34; i++) add_push(48'd200000 + i * 7, 1'b1);
        add_query(48'd200010, 48'd200300);
        add_query(48'd200100, 48'd200300);
        wait_drained();

        write_reg(REG_DELAY, 32'd100000);
        write_reg(REG_GAP, 32'd1000000);
        write_reg(REG_STALE, 32'd1000000);
        add_burst(10, 6, 30000);
        add_query(48'hFFFF_FFFF_FFFF, clock_us);
        wait_drained();
        write_reg(REG_DELAY, 32'h1FFFF);
        add_burst(6, 4, 30000);
        wait_drained();
        write_reg(REG_GAP, 32'd0);
        write_reg(REG_STALE, 32'd0);
        add_burst(4, 3, 50);
        wait_drained();

        // Random bursts; the first stretch runs with no idling on either side.
        write_reg(REG_GAP, 32'd20000);
        write_reg(REG_STALE, 32'd60000);
        write_reg(REG_DELAY, 32'd300);
        src_calm = 1'b1;
        sink_calm = 1'b1;
        for (int b = 0; b < 30; b++) begin
            if (b == 10) begin
                // The sender stops until every result so far has come back.
                src_pause = 1'b1;
                while (s_axis_tvalid || expected_forces.size() > 0) @(posedge i_clk);
                repeat (5) @(posedge i_clk);
                src_pause = 1'b0;
                src_calm = 1'b0;
                sink_calm = 1'b0;
            end
            add_burst($urandom_range(8, 3), $urandom_range(6, 2),
                      ($urandom_range(4) == 0) ? 30000 : 3000);
        end
        wait_drained();

        write_reg(REG_STALE, 32'hFFFFF);
        write_reg(REG_GAP, 32'hFFFFF);
        add_push(48'hFFFF_FFFF_FF00, 1'b1);
        add_push(48'hFFFF_FFFF_FFFF, 1'b1);
        add_query(48'hFFFF_FFFF_FF80, 48'hFFFF_FFFF_FFFF);
        wait_drained();
        // No later push can be newer than the top of the time range.
        clock_us = 48'hFFFF_FFFF_FFFF;

        // Long receiver hold while items keep coming.
        write_reg(REG_DELAY, 32'd0);
        hold_req = 1'b1;
        wait (sink_hold);
        hold_req = 1'b0;
        for (int i = 0; i < 30; i++) add_query(clock_us, clock_us);
        wait (!sink_hold);
        wait_drained();

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
